### rtl/pspr_pkg.sv
// shared constants and types for the pulsing sprite placement pipeline
package pspr_pkg;

  // phase divider: 48 restoring steps, DIV_STEPS per stage
  localparam int DIV_BITS   = 48;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  // sine unit depth
  localparam int SINE_LAT = 5;

  // placement stages after the sines
  localparam int PLACE_LAT = 5;

  localparam int LAT = DIV_STAGES + SINE_LAT + PLACE_LAT;

  // q16 taylor coefficients of sin(pi/2 u)
  localparam logic [16:0] SIN_S1 = 17'd102944;
  localparam logic [16:0] SIN_S3 = 17'd42334;
  localparam logic [16:0] SIN_S5 = 17'd5223;
  localparam logic [8:0]  SIN_S7 = 9'd307;

  localparam logic [17:0] SIN_MAX = 18'd65536;

  typedef logic signed [17:0] sine_t;

endpackage

### rtl/pspr_phase_div.sv
// pipelined restoring divider giving the 16 bit pulse phase
module pspr_phase_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] time_ms,
  input  logic [15:0] pulse_period,
  output logic [15:0] phase
);
  import pspr_pkg::*;

  logic [47:0] dvd [0:DIV_STAGES];
  logic [15:0] rem [0:DIV_STAGES];
  logic [15:0] quo [0:DIV_STAGES];
  logic [15:0] per [0:DIV_STAGES];

  assign dvd[0] = {time_ms, 16'b0};
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign per[0] = pulse_period;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [47:0] d_next;
    logic [15:0] r_next;
    logic [15:0] q_next;

    always_comb begin
      logic [16:0] t;
      d_next = dvd[g];
      r_next = rem[g];
      q_next = quo[g];
      t = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        t = {r_next, d_next[47]};
        d_next = {d_next[46:0], 1'b0};
        if (t >= {1'b0, per[g]}) begin
          r_next = 16'(t - {1'b0, per[g]});
          q_next = {q_next[14:0], 1'b1};
        end else begin
          r_next = t[15:0];
          q_next = {q_next[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd[g+1] <= d_next;
        rem[g+1] <= r_next;
        quo[g+1] <= q_next;
        per[g+1] <= per[g];
      end
    end
  end

  // zero period means zero phase
  assign phase = (per[DIV_STAGES] == 16'd0) ? 16'd0 : quo[DIV_STAGES];

endmodule

### rtl/pspr_sine.sv
// pipelined q16 sine of a 16 bit angle, polynomial per quadrant
module pspr_sine (
  input  logic                  clk,
  input  logic                  en,
  input  logic [15:0]           ang,
  output pspr_pkg::sine_t       sine
);
  import pspr_pkg::*;

  logic [14:0] t;
  logic [16:0] u;
  logic [33:0] sq;

  assign t  = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
  assign u  = {t, 2'b00};
  assign sq = u * u;

  // stage 1
  logic [16:0] u1, u2_1;
  logic        neg1;
  always_ff @(posedge clk) begin
    if (en) begin
      u1   <= u;
      u2_1 <= sq[32:16];
      neg1 <= ang[15];
    end
  end

  // stage 2
  logic [25:0] m7;
  logic [16:0] u_2, u2_2;
  logic [12:0] p5;
  logic        neg2;
  assign m7 = u2_1 * SIN_S7;
  always_ff @(posedge clk) begin
    if (en) begin
      u_2  <= u1;
      u2_2 <= u2_1;
      p5   <= 13'(SIN_S5 - {7'b0, m7[25:16]});
      neg2 <= neg1;
    end
  end

  // stage 3
  logic [29:0] m5;
  logic [16:0] u_3, u2_3;
  logic [15:0] p3;
  logic        neg3;
  assign m5 = u2_2 * p5;
  always_ff @(posedge clk) begin
    if (en) begin
      u_3  <= u_2;
      u2_3 <= u2_2;
      p3   <= 16'(SIN_S3 - {3'b0, m5[29:16]});
      neg3 <= neg2;
    end
  end

  // stage 4
  logic [32:0] m3;
  logic [16:0] u_4;
  logic [16:0] p1;
  logic        neg4;
  assign m3 = u2_3 * p3;
  always_ff @(posedge clk) begin
    if (en) begin
      u_4  <= u_3;
      p1   <= 17'(SIN_S1 - m3[32:16]);
      neg4 <= neg3;
    end
  end

  // stage 5: final product, cap and sign
  logic [33:0] m1;
  logic [17:0] mag;
  assign m1  = u_4 * p1;
  assign mag = (m1[33:16] > SIN_MAX) ? SIN_MAX : m1[33:16];
  always_ff @(posedge clk) begin
    if (en) begin
      sine <= neg4 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

### rtl/pulsing_sprite_rotate_place_top.sv
// top level of the pulsing sprite placement pipeline
// a request passes through 22 register stages before its result is valid
// throughput: one request per cycle, set by the fully pipelined phase divider
//   (12 stages of 4 restoring steps), the sine units (5 stages) and 5 placement stages
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset (rst, synchronous) clears all valid bits; payload registers are not reset
module pulsing_sprite_rotate_place_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        time_ms,
  input  logic signed [13:0] sprite_x,
  input  logic signed [13:0] sprite_y,
  input  logic [11:0]        base_size,
  input  logic [15:0]        pulse_period,
  input  logic [7:0]         pulse_depth,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  input  logic [15:0]        angle,
  input  logic               last_in_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [12:0] rect_x,
  output logic signed [12:0] rect_y,
  output logic [8:0]         rect_size,
  output logic               end_of_frame
);
  import pspr_pkg::*;

  // request fields that ride alongside the arithmetic
  typedef struct packed {
    logic signed [13:0] sx;
    logic signed [13:0] sy;
    logic [11:0]        base;
    logic [7:0]         depth;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        ang;
    logic               last;
  } side_t;

  // stage positions (side_d[k] lines up with pipeline stage k+1)
  localparam int DIV_IDX  = DIV_STAGES - 1;
  localparam int SINE_IDX = DIV_STAGES + SINE_LAT - 1;

  // global advance: the pipeline moves unless a result is held by the consumer
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  side_t side_d  [0:LAT-1];
  logic  valid_d [0:LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        valid_d[i] <= 1'b0;
      end
    end else if (en) begin
      valid_d[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        valid_d[i] <= valid_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= '{sx: sprite_x, sy: sprite_y, base: base_size, depth: pulse_depth,
                     cx: center_x, cy: center_y, ang: angle, last: last_in_frame};
      for (int i = 1; i < LAT; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  assign out_valid = valid_d[LAT-1];

  // phase = floor((time mod period) * 65536 / period) by long division
  logic [15:0] phase;
  pspr_phase_div u_div (
    .clk          (clk),
    .en           (en),
    .time_ms      (time_ms),
    .pulse_period (pulse_period),
    .phase        (phase)
  );

  // three sine units in lockstep: pulse phase, group sine, group cosine
  sine_t sin_p, sin_a, cos_a;
  logic [15:0] ang_c;
  assign ang_c = side_d[DIV_IDX].ang + 16'd16384;

  pspr_sine u_sin_p (.clk(clk), .en(en), .ang(phase),                .sine(sin_p));
  pspr_sine u_sin_a (.clk(clk), .en(en), .ang(side_d[DIV_IDX].ang), .sine(sin_a));
  pspr_sine u_cos_a (.clk(clk), .en(en), .ang(ang_c),                .sine(cos_a));

  // stage a: depth times pulse sine, the four rotation products
  logic signed [26:0] dm;
  logic signed [31:0] pxc, pys, pxs, pyc;
  always_ff @(posedge clk) begin
    if (en) begin
      dm  <= $signed({1'b0, side_d[SINE_IDX].depth}) * sin_p;
      pxc <= side_d[SINE_IDX].sx * cos_a;
      pys <= side_d[SINE_IDX].sy * sin_a;
      pxs <= side_d[SINE_IDX].sx * sin_a;
      pyc <= side_d[SINE_IDX].sy * cos_a;
    end
  end

  // stage b: scale factor in q24 (always positive), rotated offset in q.20
  logic signed [26:0] fsum;
  logic [25:0]        fac;
  logic signed [32:0] rx, ry;
  assign fsum = 27'sd16777216 + dm;
  always_ff @(posedge clk) begin
    if (en) begin
      fac <= fsum[25:0];
      rx  <= 33'(pxc) - 33'(pys);
      ry  <= 33'(pxs) + 33'(pyc);
    end
  end

  // stage c: exact size n in 2^-28 pixel, centre plus offset in q.29
  logic [37:0]        n;
  logic signed [44:0] sumx, sumy;
  always_ff @(posedge clk) begin
    if (en) begin
      n    <= side_d[SINE_IDX+2].base * fac;
      sumx <= (45'(side_d[SINE_IDX+2].cx) <<< 25) + (45'(rx) <<< 9);
      sumy <= (45'(side_d[SINE_IDX+2].cy) <<< 25) + (45'(ry) <<< 9);
    end
  end

  // stage d: left/top edge = centre minus half size (n is already half in q.29)
  logic signed [44:0] xx, yy;
  logic [8:0]         sz;
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= sumx - $signed({7'b0, n});
      yy <= sumy - $signed({7'b0, n});
      sz <= n[36:28];
    end
  end

  // stage e: divide by 2^29 truncating toward zero
  logic signed [44:0] xa, ya;
  assign xa = xx[44] ? xx + 45'sd536870911 : xx;
  assign ya = yy[44] ? yy + 45'sd536870911 : yy;
  always_ff @(posedge clk) begin
    if (en) begin
      rect_x       <= xa[41:29];
      rect_y       <= ya[41:29];
      rect_size    <= sz;
      end_of_frame <= side_d[LAT-2].last;
    end
  end

endmodule

### rtl/pspr_checker.sv
// port-level checker for the sprite placement top, with its bind
module pspr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [12:0] rect_x,
  input logic signed [12:0] rect_y,
  input logic [8:0]        rect_size,
  input logic              end_of_frame
);

  // a held result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held result lost valid");

  // a held result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(rect_x) && $stable(rect_y) &&
                               $stable(rect_size) && $stable(end_of_frame))
    else $error("held result changed");

  // input backpressure comes only from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall without held result");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pulsing_sprite_rotate_place_top pspr_checker u_pspr_checker (.*);

### test/pulsing_sprite_rotate_place_top_test.sv
// testbench for the pulsing sprite placement pipeline: directed and random requests
module pulsing_sprite_rotate_place_top_test;
  import pspr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [13:0] sprite_x;
    logic signed [13:0] sprite_y;
    logic [11:0]        base_size;
    logic [15:0]        pulse_period;
    logic [7:0]         pulse_depth;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        angle;
    logic               last_in_frame;
  } sprite_req_t;

  typedef struct packed {
    logic signed [12:0] rect_x;
    logic signed [12:0] rect_y;
    logic [8:0]         rect_size;
    logic               end_of_frame;
  } rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] time_ms = '0;
  logic signed [13:0] sprite_x = '0;
  logic signed [13:0] sprite_y = '0;
  logic [11:0] base_size = '0;
  logic [15:0] pulse_period = 16'd1;
  logic [7:0] pulse_depth = '0;
  logic signed [15:0] center_x = '0;
  logic signed [15:0] center_y = '0;
  logic [15:0] angle = '0;
  logic last_in_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [12:0] rect_x;
  logic signed [12:0] rect_y;
  logic [8:0] rect_size;
  logic end_of_frame;

  rect_t pending_rects[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_enable = 1'b1;

  pulsing_sprite_rotate_place_top dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // q16 sine of a 16 bit turn angle, polynomial per quadrant
  function automatic longint sine_of_turn(logic [15:0] a);
    logic [1:0] quad;
    longint unsigned t, u, u2, p;
    quad = a[15:14];
    t = quad[0] ? 64'(16384 - a[13:0]) : 64'(a[13:0]);
    u = t << 2;
    u2 = (u * u) >> 16;
    p = 64'd5223 - ((u2 * 64'd307) >> 16);
    p = 64'd42334 - ((u2 * p) >> 16);
    p = 64'd102944 - ((u2 * p) >> 16);
    p = (u * p) >> 16;
    if (p > 64'd65536) p = 64'd65536;
    return quad[1] ? -longint'(p) : longint'(p);
  endfunction

  function automatic rect_t place_sprite(sprite_req_t r);
    longint unsigned rem;
    logic [15:0] ph;
    longint f, n, sn, cs, rx, ry, xx, yy;
    rect_t o;
    ph = '0;
    if (r.pulse_period != 0) begin
      rem = r.time_ms % r.pulse_period;
      ph = 16'((rem << 16) / r.pulse_period);
    end
    f = (longint'(1) << 24) + longint'(r.pulse_depth) * sine_of_turn(ph);
    n = longint'(r.base_size) * f;
    sn = sine_of_turn(r.angle);
    cs = sine_of_turn(r.angle + 16'd16384);
    rx = longint'(r.sprite_x) * cs - longint'(r.sprite_y) * sn;
    ry = longint'(r.sprite_x) * sn + longint'(r.sprite_y) * cs;
    xx = longint'(r.center_x) * (longint'(1) << 25) + rx * 512 - n;
    yy = longint'(r.center_y) * (longint'(1) << 25) + ry * 512 - n;
    // division truncates toward zero as in c
    o.rect_x = 13'(xx / (longint'(1) << 29));
    o.rect_y = 13'(yy / (longint'(1) << 29));
    o.rect_size = 9'(n / (longint'(1) << 28));
    o.end_of_frame = r.last_in_frame;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // send one request, sometimes with a random burst of idle cycles before it
  task automatic send_sprite(sprite_req_t r);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {time_ms, sprite_x, sprite_y, base_size, pulse_period, pulse_depth,
     center_x, center_y, angle, last_in_frame} <= r;
    pending_rects.push_back(place_sprite(r));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic finish_sending;
    in_valid <= 1'b0;
  endtask

  function automatic sprite_req_t random_sprite();
    sprite_req_t r;
    r = sprite_req_t'(145'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    // period of zero is legal but rare
    if ($urandom_range(0, 30) == 0) r.pulse_period = '0;
    // short periods about half the time so the phase spans full turns
    else if ($urandom_range(0, 1)) r.pulse_period = 16'($urandom_range(1, 2000));
    if ($urandom_range(0, 15) == 0) r.base_size = '0;
    return r;
  endfunction

  // extremes of every field, the zero period and zero size cases and eight angle steps
  task automatic test_directed;
    sprite_req_t r;
    r = '0;
    send_sprite(r);
    r = '1;
    send_sprite(r);
    r = '0; r.sprite_x = 14'sh1fff; r.sprite_y = 14'sh1fff; r.base_size = 12'hfff;
    r.pulse_period = 16'hffff; r.pulse_depth = 8'hff; r.time_ms = 32'hffff_ffff;
    r.center_x = 16'sh7fff; r.center_y = 16'sh7fff; r.angle = 16'd8192;
    send_sprite(r);
    r.sprite_x = 14'sh2000; r.sprite_y = 14'sh2000;
    r.center_x = 16'sh8000; r.center_y = 16'sh8000;
    send_sprite(r);
    // zero period leaves the size unscaled
    r.pulse_period = '0; r.last_in_frame = 1'b1;
    send_sprite(r);
    // zero base size centres on the rotated point
    r.base_size = '0; r.pulse_period = 16'd100; r.time_ms = 32'd25;
    send_sprite(r);
    for (int q = 0; q < 8; q++) begin
      r = '0; r.angle = 16'(q * 8192); r.sprite_x = 14'sd1600; r.sprite_y = -14'sd800;
      r.base_size = 12'd800; r.pulse_depth = 8'd200; r.pulse_period = 16'd8;
      r.time_ms = 32'(q); r.last_in_frame = q[0];
      send_sprite(r);
    end
    finish_sending();
  endtask

  // sender holds off until the pipeline has drained
  task automatic test_drain_pause;
    finish_sending();
    while (pending_rects.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_sprite(random_sprite());
    finish_sending();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_sprite(random_sprite());
    finish_sending();
  endtask

  // receiver stalls in random bursts while idling is enabled
  initial begin
    int burst;
    @(negedge rst);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expected rectangle
  always @(posedge clk) begin
    rect_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rects.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_rects.pop_front();
        if (rect_x !== want.rect_x) report_mismatch("rect_x", rect_x, want.rect_x);
        if (rect_y !== want.rect_y) report_mismatch("rect_y", rect_y, want.rect_y);
        if (rect_size !== want.rect_size)
          report_mismatch("rect_size", rect_size, want.rect_size);
        if (end_of_frame !== want.end_of_frame)
          report_mismatch("end_of_frame", end_of_frame, want.end_of_frame);
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(700);
    // last stretch runs at full rate on both sides
    idle_enable = 1'b0;
    test_random(80);
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0 && pending_rects.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### sim.f
rtl/pspr_pkg.sv
rtl/pspr_phase_div.sv
rtl/pspr_sine.sv
rtl/pulsing_sprite_rotate_place_top.sv
rtl/pspr_checker.sv
test/pulsing_sprite_rotate_place_top_test.sv
